### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/vcsn_pkg.sv
// ----------------------------------------------------------------------------
// Vector clock snapshot node package
// Types, widths and codes shared by the snapshot node modules.
// ----------------------------------------------------------------------------
package vcsn_pkg;

   // Number of processes in the vector clock and width of one clock entry.
   localparam int NUM_NODES   = 3;
   localparam int CLOCK_WIDTH = 32;

   // Field widths.
   localparam int OP_W   = 3;
   localparam int NODE_W = 2;
   localparam int KIND_W = 3;

   // Operation codes of an input item.
   localparam logic [OP_W-1:0] OP_LOCAL  = 3'd0;
   localparam logic [OP_W-1:0] OP_SEND   = 3'd1;
   localparam logic [OP_W-1:0] OP_RECV   = 3'd2;
   localparam logic [OP_W-1:0] OP_MARKER = 3'd3;
   localparam logic [OP_W-1:0] OP_INIT   = 3'd4;

   // Kinds of result item.
   localparam logic [KIND_W-1:0] KIND_REPORT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_MESSAGE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MARKER  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SNAP    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TRANSIT = 3'd4;

   // One full vector clock.
   typedef logic [NUM_NODES-1:0][CLOCK_WIDTH-1:0] clock_vec_type;

   // Commands from the sequencer to the clock unit.
   typedef struct packed {
      logic merge;
      logic bump;
      logic record;
   } clk_ctrl_type;

endpackage

### rtl/vcsn_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one operation item into the snapshot node.
// ----------------------------------------------------------------------------
interface vcsn_req_if import vcsn_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [NODE_W-1:0]      peer;
   logic [CLOCK_WIDTH-1:0] in_clock_0;
   logic [CLOCK_WIDTH-1:0] in_clock_1;
   logic [CLOCK_WIDTH-1:0] in_clock_2;

   modport source (output valid, operation, peer, in_clock_0, in_clock_1, in_clock_2,
                   input ready);
   modport sink (input valid, operation, peer, in_clock_0, in_clock_1, in_clock_2,
                 output ready);
endinterface

### rtl/vcsn_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one result item out of the snapshot node.
// ----------------------------------------------------------------------------
interface vcsn_rsp_if import vcsn_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [NODE_W-1:0]      target;
   logic [CLOCK_WIDTH-1:0] out_clock_0;
   logic [CLOCK_WIDTH-1:0] out_clock_1;
   logic [CLOCK_WIDTH-1:0] out_clock_2;
   logic                   dropped;
   logic                   last;

   modport source (output valid, kind, target, out_clock_0, out_clock_1, out_clock_2,
                   dropped, last, input ready);
   modport sink (input valid, kind, target, out_clock_0, out_clock_1, out_clock_2,
                 dropped, last, output ready);
endinterface

### rtl/vcsn_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Carries a write of the node rank register.
// ----------------------------------------------------------------------------
interface vcsn_csr_if import vcsn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### rtl/vcsn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module vcsn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/vcsn_clock.sv
// ----------------------------------------------------------------------------
// Clock unit
// Holds the local and recorded vector clocks, merges and advances them.
// ----------------------------------------------------------------------------
module vcsn_clock import vcsn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  clk_ctrl_type      ctrl,
   input  logic [NODE_W-1:0] me,
   input  clock_vec_type     msg,
   output clock_vec_type     bumped,
   output clock_vec_type     recorded
);

   clock_vec_type local_ff, local_in;
   clock_vec_type recorded_ff, recorded_in;
   clock_vec_type merged;

   // Elementwise maximum with the incoming clock, and the own entry
   // advanced with saturation at all ones.
   always_comb begin
      for (int i = 0; i < NUM_NODES; i++) begin
         merged[i] = (msg[i] > local_ff[i]) ? msg[i] : local_ff[i];
         if (NODE_W'(i) == me && local_ff[i] != '1) begin
            bumped[i] = local_ff[i] + 1'b1;
         end else begin
            bumped[i] = local_ff[i];
         end
      end
   end

   // Next clock values.
   always_comb begin
      if (ctrl.merge) begin
         local_in = merged;
      end else if (ctrl.bump) begin
         local_in = bumped;
      end else begin
         local_in = local_ff;
      end
      recorded_in = ctrl.record ? local_ff : recorded_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff    <= '0;
         recorded_ff <= '0;
      end else begin
         local_ff    <= local_in;
         recorded_ff <= recorded_in;
      end
   end

   assign recorded = recorded_ff;

endmodule

### rtl/vector_clock_snapshot_node_unit.sv
// ----------------------------------------------------------------------------
// Vector clock snapshot node
// One process node with a vector clock and marker based snapshots.
// ----------------------------------------------------------------------------
// The node takes one item at a time: req ready is high only between items,
// and the rank register is written only then as well. A local event, send or
// receive passes through capture, execute and report before its result is
// offered, and the next item can be taken in the cycle in which that result is
// first offered. An item that causes no result is done after capture and
// execute. A marker or an initiate adds to those a step for each marker sent
// to another node, one more when the own rank lies below the highest other
// rank and is stepped over in the marker order, one for the snapshot clock, a
// seek and a drain step for each stored in-transit item, as each is fetched
// through the single registered read port of the in-transit RAM, and a step
// for each channel that the drain passes over on its way to the last stored
// item. A stalled response holds the current step while it waits.
// The in-transit RAM is not cleared after reset; per-channel fill counts
// decide which entries are read.

`include "assert_macros.svh"

module vector_clock_snapshot_node_unit import vcsn_pkg::*; #(
   parameter int TRANSIT_DEPTH = 5
) (
   input  logic       clock,
   input  logic       reset,
   vcsn_req_if.sink   req_chan,
   vcsn_rsp_if.source rsp_chan,
   vcsn_csr_if.sink   csr_chan
);

   localparam int CNT_W      = $clog2(TRANSIT_DEPTH + 1);
   localparam int RAM_DEPTH  = NUM_NODES * TRANSIT_DEPTH;
   localparam int ADDR_W     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_REPORT = 3'd2;
   localparam logic [2:0] S_MARK   = 3'd3;
   localparam logic [2:0] S_SNAP   = 3'd4;
   localparam logic [2:0] S_SEEK   = 3'd5;
   localparam logic [2:0] S_DRAIN  = 3'd6;

   // Control state.
   logic [2:0]           state_ff, state_in;
   logic [NODE_W-1:0]    rank_ff, rank_in;
   logic                 active_ff, active_in;
   logic [NUM_NODES-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0]     count_ff [NUM_NODES];
   logic [CNT_W-1:0]     count_in [NUM_NODES];
   logic                 drop_ff, drop_in;
   logic                 complete_ff, complete_in;
   logic [NODE_W-1:0]    idx_ff, idx_in;
   logic [NODE_W-1:0]    ch_ff, ch_in;
   logic [CNT_W-1:0]     j_ff, j_in;

   // Captured item.
   logic [OP_W-1:0]      op_ff;
   logic [NODE_W-1:0]    peer_ff;
   clock_vec_type        msg_ff;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    kind_ff;
   logic [NODE_W-1:0]    target_ff;
   clock_vec_type        clock_ff;
   logic                 dropped_ff;
   logic                 last_ff;

   // Internal signals.
   logic                 req_fire;
   logic                 out_free;
   logic [NODE_W-1:0]    me;
   logic [NODE_W-1:0]    last_other;
   logic                 peer_bad;
   logic [NUM_NODES-1:0] seen_new;
   logic                 complete_new;
   logic                 any_transit;
   logic                 later;
   logic                 more_after;
   logic                 count_over;
   clk_ctrl_type         clk_ctrl;
   clock_vec_type        bumped;
   clock_vec_type        recorded;
   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [NUM_NODES*CLOCK_WIDTH-1:0] ram_rd_data;
   logic                 emit;
   logic [KIND_W-1:0]    emit_kind;
   logic [NODE_W-1:0]    emit_target;
   clock_vec_type        emit_clock;
   logic                 emit_drop;
   logic                 emit_last;

   // Handshakes.
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Effective rank and the highest numbered other node.
   assign me         = (int'(rank_ff) >= NUM_NODES) ? NODE_W'(NUM_NODES - 1) : rank_ff;
   assign last_other = (me == NODE_W'(NUM_NODES - 1)) ? NODE_W'(NUM_NODES - 2)
                                                      : NODE_W'(NUM_NODES - 1);
   assign peer_bad   = (int'(peer_ff) >= NUM_NODES);

   // Marker state after this item, and whether every other channel is marked.
   always_comb begin
      seen_new     = seen_ff;
      complete_new = 1'b1;
      for (int i = 0; i < NUM_NODES; i++) begin
         if (op_ff == OP_MARKER && NODE_W'(i) == peer_ff) begin
            seen_new[i] = 1'b1;
         end
         if (op_ff == OP_INIT && NODE_W'(i) == me) begin
            seen_new[i] = 1'b1;
         end
      end
      for (int i = 0; i < NUM_NODES; i++) begin
         if (NODE_W'(i) != me && !seen_new[i]) begin
            complete_new = 1'b0;
         end
      end
   end

   // Look-ahead over the in-transit counts for the drain.
   always_comb begin
      any_transit = 1'b0;
      later       = 1'b0;
      count_over  = 1'b0;
      for (int i = 0; i < NUM_NODES; i++) begin
         if (NODE_W'(i) != me && count_ff[i] != '0) begin
            any_transit = 1'b1;
            if (NODE_W'(i) > ch_ff) begin
               later = 1'b1;
            end
         end
         if (count_ff[i] > CNT_W'(TRANSIT_DEPTH)) begin
            count_over = 1'b1;
         end
      end
      more_after = later ||
                   ((CNT_W + 1)'(j_ff) + 1'b1 < (CNT_W + 1)'(count_ff[ch_ff]));
   end

   // RAM addresses: channel row times depth plus slot.
   assign ram_wr_addr = ADDR_W'(peer_ff) * ADDR_W'(TRANSIT_DEPTH)
                      + ADDR_W'(count_ff[peer_ff]);
   assign ram_rd_addr = ADDR_W'(ch_ff) * ADDR_W'(TRANSIT_DEPTH) + ADDR_W'(j_ff);

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      seen_in     = seen_ff;
      count_in    = count_ff;
      drop_in     = drop_ff;
      complete_in = complete_ff;
      idx_in      = idx_ff;
      ch_in       = ch_ff;
      j_in        = j_ff;
      clk_ctrl    = '0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      emit        = 1'b0;
      emit_kind   = KIND_REPORT;
      emit_target = me;
      emit_clock  = '0;
      emit_drop   = 1'b0;
      emit_last   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end

         // Update the snapshot state and choose the results to send.
         S_EXEC: begin
            state_in    = S_IDLE;
            drop_in     = 1'b0;
            complete_in = complete_new;
            idx_in      = '0;
            case (op_ff)
               OP_LOCAL: begin
                  state_in = S_REPORT;
               end
               OP_SEND: begin
                  if (!peer_bad) begin
                     state_in = S_REPORT;
                  end
               end
               OP_RECV: begin
                  if (!peer_bad) begin
                     if (active_ff && !seen_ff[peer_ff]) begin
                        if (count_ff[peer_ff] < CNT_W'(TRANSIT_DEPTH)) begin
                           ram_wr_en          = 1'b1;
                           count_in[peer_ff]  = count_ff[peer_ff] + 1'b1;
                        end else begin
                           drop_in = 1'b1;
                        end
                     end
                     clk_ctrl.merge = 1'b1;
                     state_in       = S_REPORT;
                  end
               end
               OP_MARKER: begin
                  if (!peer_bad && peer_ff != me) begin
                     seen_in = seen_new;
                     if (!active_ff) begin
                        active_in       = 1'b1;
                        clk_ctrl.record = 1'b1;
                        state_in        = S_MARK;
                     end else if (complete_new) begin
                        state_in = S_SNAP;
                     end
                  end
               end
               OP_INIT: begin
                  if (!active_ff) begin
                     active_in       = 1'b1;
                     clk_ctrl.record = 1'b1;
                     seen_in         = seen_new;
                     state_in        = S_MARK;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // Clock report or outgoing message, with the own entry advanced.
         S_REPORT: begin
            emit_kind   = (op_ff == OP_SEND) ? KIND_MESSAGE : KIND_REPORT;
            emit_target = (op_ff == OP_SEND) ? peer_ff : me;
            emit_clock  = bumped;
            emit_drop   = drop_ff;
            emit_last   = 1'b1;
            if (out_free) begin
               emit          = 1'b1;
               clk_ctrl.bump = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // Markers to every other node in rank order.
         S_MARK: begin
            if (idx_ff == me) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               emit_kind   = KIND_MARKER;
               emit_target = idx_ff;
               emit_last   = (idx_ff == last_other) && !complete_ff;
               if (out_free) begin
                  emit = 1'b1;
                  if (idx_ff == last_other) begin
                     state_in = complete_ff ? S_SNAP : S_IDLE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end

         // Recorded clock, then the drain or the end of the snapshot.
         S_SNAP: begin
            emit_kind   = KIND_SNAP;
            emit_clock  = recorded;
            emit_last   = !any_transit;
            if (out_free) begin
               emit  = 1'b1;
               ch_in = '0;
               j_in  = '0;
               if (any_transit) begin
                  state_in = S_SEEK;
               end else begin
                  seen_in   = '0;
                  active_in = 1'b0;
                  count_in  = '{default: '0};
                  state_in  = S_IDLE;
               end
            end
         end

         // Step to the next stored item and start its read.
         S_SEEK: begin
            if (ch_ff == me || j_ff >= count_ff[ch_ff]) begin
               ch_in = ch_ff + 1'b1;
               j_in  = '0;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_DRAIN;
            end
         end

         // Send the stored item read in the seek state.
         S_DRAIN: begin
            emit_kind   = KIND_TRANSIT;
            emit_target = ch_ff;
            emit_clock  = clock_vec_type'(ram_rd_data);
            emit_last   = !more_after;
            if (out_free) begin
               emit = 1'b1;
               if (more_after) begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_SEEK;
               end else begin
                  seen_in   = '0;
                  active_in = 1'b0;
                  count_in  = '{default: '0};
                  state_in  = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Rank register and response valid.
   always_comb begin
      rank_in      = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : rank_ff;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rank_ff      <= '0;
         active_ff    <= 1'b0;
         seen_ff      <= '0;
         count_ff     <= '{default: '0};
         drop_ff      <= 1'b0;
         complete_ff  <= 1'b0;
         idx_ff       <= '0;
         ch_ff        <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rank_ff      <= rank_in;
         active_ff    <= active_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         complete_ff  <= complete_in;
         idx_ff       <= idx_in;
         ch_ff        <= ch_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item capture and response payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_chan.operation;
         peer_ff   <= req_chan.peer;
         msg_ff[0] <= req_chan.in_clock_0;
         msg_ff[1] <= req_chan.in_clock_1;
         msg_ff[2] <= req_chan.in_clock_2;
      end
      if (emit) begin
         kind_ff    <= emit_kind;
         target_ff  <= emit_target;
         clock_ff   <= emit_clock;
         dropped_ff <= emit_drop;
         last_ff    <= emit_last;
      end
   end

   // Clock unit.
   vcsn_clock u_clock (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (clk_ctrl),
      .me       (me),
      .msg      (msg_ff),
      .bumped   (bumped),
      .recorded (recorded)
   );

   // In-transit store, one row of TRANSIT_DEPTH slots per channel.
   vcsn_ram #(
      .WIDTH (NUM_NODES * CLOCK_WIDTH),
      .DEPTH (RAM_DEPTH)
   ) u_transit_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (msg_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Response outputs.
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = kind_ff;
   assign rsp_chan.target      = target_ff;
   assign rsp_chan.out_clock_0 = clock_ff[0];
   assign rsp_chan.out_clock_1 = clock_ff[1];
   assign rsp_chan.out_clock_2 = clock_ff[2];
   assign rsp_chan.dropped     = dropped_ff;
   assign rsp_chan.last        = last_ff;

   // Checks.
   `ASSERT_IMPLIES(a_idle_no_marks, !active_ff, seen_ff == '0, "Channel marked with no snapshot.")
   `ASSERT_ALWAYS(a_count_bound, !count_over, "In-transit count above store depth.")
   `ASSERT_IMPLIES(a_drain_channel, state_ff == S_DRAIN, ch_ff != me, "Draining own channel.")
   `ASSERT_NEXT(a_last_ends, emit && emit_last, state_ff == S_IDLE, "Item ran past its last result.")

endmodule

### test/vector_clock_snapshot_node_unit_tb.sv
// ----------------------------------------------------------------------------
// Vector clock snapshot node testbench
// Drives operation items into the node under random idling and a long
// response stall, predicts every result item from a private copy of the
// clock, snapshot and in-transit state, and checks each result as it leaves.
// The rank register is rewritten between phases, including out of range.
// ----------------------------------------------------------------------------
module vector_clock_snapshot_node_unit_tb import vcsn_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TRANSIT_DEPTH = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_CYCLES  = 160;
   localparam clock_vec_type NO_CLOCK = '0;
   localparam clock_vec_type SAT_CLOCK = '1;

   // One operation item and one result item.
   typedef struct {
      logic [OP_W-1:0]   operation;
      logic [NODE_W-1:0] peer;
      clock_vec_type     clk;
   } node_op_t;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [NODE_W-1:0] target;
      clock_vec_type     clk;
      logic              dropped;
      logic              last;
   } node_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   vcsn_req_if req_chan ();
   vcsn_rsp_if rsp_chan ();
   vcsn_csr_if csr_chan ();

   vector_clock_snapshot_node_unit #(.TRANSIT_DEPTH(TRANSIT_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Items still to be offered and results still to arrive.
   node_op_t     op_backlog[$];
   node_result_t due_results[$];

   // Private copy of the node state.
   logic [NODE_W-1:0] node_rank_q = '0;
   clock_vec_type     own_clock = '0;
   clock_vec_type     snap_clock = '0;
   bit                snap_active = 1'b0;
   bit                marker_seen [NUM_NODES];
   int                transit_fill [NUM_NODES];
   clock_vec_type     transit_store [NUM_NODES][TRANSIT_DEPTH];

   int fault_count = 0;
   bit op_taken = 1'b0;
   bit steady_flow = 1'b0;
   int stall_asked = 0;
   int stall_granted = 0;
   int stall_left = 0;

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic logic [NODE_W-1:0] eff_rank(logic [NODE_W-1:0] rank);
      return (rank >= NUM_NODES) ? NODE_W'(NUM_NODES - 1) : rank;
   endfunction

   function automatic void push_result(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] target,
                                       clock_vec_type clk, logic dropped);
      node_result_t r;
      r.kind    = kind;
      r.target  = target;
      r.clk     = clk;
      r.dropped = dropped;
      r.last    = 1'b0;
      due_results.push_back(r);
   endfunction

   // The own entry saturates at all ones.
   function automatic void bump_own(logic [NODE_W-1:0] me);
      if (own_clock[me] != '1) begin
         own_clock[me] = own_clock[me] + 1'b1;
      end
   endfunction

   function automatic void send_markers(logic [NODE_W-1:0] me);
      for (int i = 0; i < NUM_NODES; i++) begin
         if (i != me) begin
            push_result(KIND_MARKER, NODE_W'(i), NO_CLOCK, 1'b0);
         end
      end
   endfunction

   // Once every other channel is marked, report the snapshot and flush the store.
   function automatic void close_snapshot(logic [NODE_W-1:0] me);
      for (int i = 0; i < NUM_NODES; i++) begin
         if (i != me && !marker_seen[i]) begin
            return;
         end
      end
      push_result(KIND_SNAP, me, snap_clock, 1'b0);
      for (int i = 0; i < NUM_NODES; i++) begin
         if (i != me) begin
            for (int j = 0; j < transit_fill[i]; j++) begin
               push_result(KIND_TRANSIT, NODE_W'(i), transit_store[i][j], 1'b0);
            end
         end
      end
      for (int i = 0; i < NUM_NODES; i++) begin
         transit_fill[i] = 0;
         marker_seen[i]  = 1'b0;
      end
      snap_active = 1'b0;
   endfunction

   // Applies one accepted item to the state and queues the results it causes.
   function automatic void step_vector_clock(node_op_t op_item);
      logic [NODE_W-1:0] me;
      logic [NODE_W-1:0] p;
      logic              drop;
      int                first;
      node_result_t      tail;
      me    = eff_rank(node_rank_q);
      p     = op_item.peer;
      drop  = 1'b0;
      first = due_results.size();
      case (op_item.operation)
         OP_LOCAL: begin
            bump_own(me);
            push_result(KIND_REPORT, me, own_clock, 1'b0);
         end
         OP_SEND: begin
            if (p < NUM_NODES) begin
               bump_own(me);
               push_result(KIND_MESSAGE, p, own_clock, 1'b0);
            end
         end
         OP_RECV: begin
            if (p < NUM_NODES) begin
               // Record as in transit while the channel is still unmarked.
               if (snap_active && !marker_seen[p]) begin
                  if (transit_fill[p] < TRANSIT_DEPTH) begin
                     transit_store[p][transit_fill[p]] = op_item.clk;
                     transit_fill[p]++;
                  end else begin
                     drop = 1'b1;
                  end
               end
               for (int i = 0; i < NUM_NODES; i++) begin
                  if (op_item.clk[i] > own_clock[i]) begin
                     own_clock[i] = op_item.clk[i];
                  end
               end
               bump_own(me);
               push_result(KIND_REPORT, me, own_clock, drop);
            end
         end
         OP_MARKER: begin
            if (p < NUM_NODES && p != me) begin
               if (!snap_active) begin
                  snap_active = 1'b1;
                  snap_clock  = own_clock;
                  marker_seen[p] = 1'b1;
                  send_markers(me);
               end else begin
                  marker_seen[p] = 1'b1;
               end
               close_snapshot(me);
            end
         end
         OP_INIT: begin
            if (!snap_active) begin
               snap_active = 1'b1;
               snap_clock  = own_clock;
               marker_seen[me] = 1'b1;
               send_markers(me);
               close_snapshot(me);
            end
         end
         default: begin
         end
      endcase
      // Flag the final result of this item.
      if (due_results.size() > first) begin
         tail = due_results.pop_back();
         tail.last = 1'b1;
         due_results.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------

   function automatic void add_op(logic [OP_W-1:0] operation, logic [NODE_W-1:0] peer,
                                  clock_vec_type clk);
      node_op_t o;
      o.operation = operation;
      o.peer      = peer;
      o.clk       = clk;
      op_backlog.push_back(o);
   endfunction

   // Mostly small entries, so that merges go both ways, with some full-width ones.
   function automatic clock_vec_type rand_clocks();
      clock_vec_type c;
      for (int i = 0; i < NUM_NODES; i++) begin
         c[i] = ($urandom_range(0, 99) < 80) ? CLOCK_WIDTH'($urandom_range(0, 600))
                                             : CLOCK_WIDTH'($urandom);
      end
      return c;
   endfunction

   // A well-formed snapshot: a start, traffic on the channels, then the markers.
   function automatic void add_snapshot_run(logic [NODE_W-1:0] me);
      logic [NODE_W-1:0] open_chans[$];
      logic [NODE_W-1:0] src;
      int                pick;
      int                roll;
      for (int i = 0; i < NUM_NODES; i++) begin
         if (i != me) begin
            open_chans.push_back(NODE_W'(i));
         end
      end
      if ($urandom_range(0, 1) == 1) begin
         add_op(OP_INIT, NODE_W'($urandom_range(0, 3)), rand_clocks());
      end else begin
         pick = $urandom_range(0, open_chans.size() - 1);
         add_op(OP_MARKER, open_chans[pick], rand_clocks());
         open_chans.delete(pick);
      end
      repeat ($urandom_range(2, 13)) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) begin
            src = (open_chans.size() != 0 && $urandom_range(0, 99) < 70)
                  ? open_chans[0] : NODE_W'($urandom_range(0, NUM_NODES - 1));
            add_op(OP_RECV, src, rand_clocks());
         end else if (roll < 75) begin
            add_op(OP_LOCAL, NODE_W'($urandom_range(0, 3)), rand_clocks());
         end else if (roll < 90) begin
            add_op(OP_SEND, NODE_W'($urandom_range(0, NUM_NODES - 1)), rand_clocks());
         end else if (open_chans.size() != 0) begin
            add_op(OP_MARKER, open_chans[0], rand_clocks());
            open_chans.delete(0);
         end
      end
      while (open_chans.size() != 0) begin
         pick = $urandom_range(0, open_chans.size() - 1);
         add_op(OP_MARKER, open_chans[pick], rand_clocks());
         open_chans.delete(pick);
      end
   endfunction

   // Snapshot runs mixed with single items, some of them malformed.
   function automatic void add_random_ops(int count, logic [NODE_W-1:0] me);
      int n;
      int mark;
      logic [OP_W-1:0]   operation;
      logic [NODE_W-1:0] peer;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 99) < 55) begin
            mark = op_backlog.size();
            add_snapshot_run(me);
            n += op_backlog.size() - mark;
         end else begin
            operation = ($urandom_range(0, 99) < 8) ? OP_W'($urandom_range(5, 7))
                                                    : OP_W'($urandom_range(0, 4));
            peer = ($urandom_range(0, 99) < 8) ? NODE_W'(3)
                                               : NODE_W'($urandom_range(0, NUM_NODES - 1));
            add_op(operation, peer, rand_clocks());
            n++;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------

   // An accepted item is predicted at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         step_vector_clock(op_backlog.pop_front());
         op_taken = 1'b1;
      end
   end

   // A new item is offered only once the previous one has gone.
   always @(negedge clock) begin
      if (op_taken || !req_chan.valid) begin
         op_taken = 1'b0;
         if (!reset && op_backlog.size() != 0 &&
             (steady_flow || $urandom_range(0, 99) >= 13)) begin
            req_chan.valid      <= 1'b1;
            req_chan.operation  <= op_backlog[0].operation;
            req_chan.peer       <= op_backlog[0].peer;
            req_chan.in_clock_0 <= op_backlog[0].clk[0];
            req_chan.in_clock_1 <= op_backlog[0].clk[1];
            req_chan.in_clock_2 <= op_backlog[0].clk[2];
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor
   // ---------------------------------------------------------------------

   // Long hold-off of the response side, started on request.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_asked != stall_granted) begin
         stall_granted <= stall_asked;
         stall_left    <= STALL_CYCLES;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= (stall_left == 0) && (steady_flow || $urandom_range(0, 99) >= 13);
   end

   task automatic check_field(string name, logic [CLOCK_WIDTH-1:0] want,
                              logic [CLOCK_WIDTH-1:0] got);
      if (want !== got) begin
         fault_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      node_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (due_results.size() == 0) begin
            fault_count++;
            $display("%0t: result item with none due, expected nothing, actual kind %0d",
                     $time, rsp_chan.kind);
         end else begin
            want = due_results.pop_front();
            check_field("kind", CLOCK_WIDTH'(want.kind), CLOCK_WIDTH'(rsp_chan.kind));
            check_field("target", CLOCK_WIDTH'(want.target), CLOCK_WIDTH'(rsp_chan.target));
            check_field("out_clock_0", want.clk[0], rsp_chan.out_clock_0);
            check_field("out_clock_1", want.clk[1], rsp_chan.out_clock_1);
            check_field("out_clock_2", want.clk[2], rsp_chan.out_clock_2);
            check_field("dropped", CLOCK_WIDTH'(want.dropped), CLOCK_WIDTH'(rsp_chan.dropped));
            check_field("last", CLOCK_WIDTH'(want.last), CLOCK_WIDTH'(rsp_chan.last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------

   // Waits until nothing is left to send or to receive, then lets the node settle.
   task automatic wait_quiet();
      while (op_backlog.size() != 0 || req_chan.valid || due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rank(logic [NODE_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) begin
         @(posedge clock);
      end
      node_rank_q = value;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      for (int i = 0; i < NUM_NODES; i++) begin
         marker_seen[i]  = 1'b0;
         transit_fill[i] = 0;
      end
      req_chan.valid      = 1'b0;
      req_chan.operation  = OP_LOCAL;
      req_chan.peer       = '0;
      req_chan.in_clock_0 = '0;
      req_chan.in_clock_1 = '0;
      req_chan.in_clock_2 = '0;
      rsp_chan.ready      = 1'b0;
      csr_chan.valid      = 1'b0;
      csr_chan.data       = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed items at rank 0: every operation, ignored items, overflow.
      write_rank(2'd0);
      add_op(OP_LOCAL, 2'd3, NO_CLOCK);
      add_op(OP_SEND, 2'd1, NO_CLOCK);
      add_op(OP_SEND, 2'd2, NO_CLOCK);
      add_op(OP_SEND, 2'd3, NO_CLOCK);
      add_op(OP_RECV, 2'd1, {32'd9, 32'd7, 32'd5});
      add_op(OP_RECV, 2'd3, SAT_CLOCK);
      add_op(OP_W'(5), 2'd1, rand_clocks());
      add_op(OP_W'(7), 2'd3, SAT_CLOCK);
      add_op(OP_MARKER, 2'd0, NO_CLOCK);
      add_op(OP_INIT, 2'd0, NO_CLOCK);
      add_op(OP_INIT, 2'd1, NO_CLOCK);
      repeat (5) add_op(OP_RECV, 2'd1, rand_clocks());
      // The sixth message on this channel finds the store full.
      repeat (6) add_op(OP_RECV, 2'd2, rand_clocks());
      add_op(OP_MARKER, 2'd1, NO_CLOCK);
      add_op(OP_MARKER, 2'd2, NO_CLOCK);
      // A snapshot started by a marker rather than by initiation.
      add_op(OP_MARKER, 2'd2, NO_CLOCK);
      add_op(OP_MARKER, 2'd1, NO_CLOCK);
      wait_quiet();

      // Random phase with a long response stall while items keep coming.
      write_rank(2'd2);
      stall_asked++;
      add_random_ops(75, eff_rank(2'd2));
      wait_quiet();

      // Same rank, no idling on either side.
      steady_flow = 1'b1;
      add_random_ops(75, eff_rank(2'd2));
      wait_quiet();
      steady_flow = 1'b0;

      write_rank(2'd1);
      add_random_ops(70, eff_rank(2'd1));
      wait_quiet();

      // Out of range rank, ending with saturated clock entries.
      write_rank(2'd3);
      add_random_ops(70, eff_rank(2'd3));
      add_op(OP_RECV, 2'd0, SAT_CLOCK);
      add_op(OP_LOCAL, 2'd0, NO_CLOCK);
      add_op(OP_SEND, 2'd1, NO_CLOCK);
      add_op(OP_RECV, 2'd1, NO_CLOCK);
      wait_quiet();

      if (fault_count == 0) begin
         $display("vector_clock_snapshot_node_unit verification clean");
      end else begin
         $display("vector_clock_snapshot_node_unit verification failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #2_000_000;
      $display("vector_clock_snapshot_node_unit verification failed");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/vcsn_pkg.sv
rtl/vcsn_req_if.sv
rtl/vcsn_rsp_if.sv
rtl/vcsn_csr_if.sv
rtl/vcsn_ram.sv
rtl/vcsn_clock.sv
rtl/vector_clock_snapshot_node_unit.sv
test/vector_clock_snapshot_node_unit_tb.sv
